>>> sv/wdre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wdre_pkg;
	localparam int WINDOW_MAX = 64;
	localparam int IDX_W = $clog2(WINDOW_MAX);
	localparam int CNT_W = IDX_W + 1;
	localparam int BUF_FRAC = 12;
	localparam logic [30:0] QTY_MAX = 31'h7FFFFFFF;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [2:0] REG_USE_AVERAGE = 3'd0;
	localparam logic [2:0] REG_BUFFER_FACTOR = 3'd1;
	localparam logic [2:0] REG_EMPTY_THRESHOLD = 3'd2;
	localparam logic [2:0] REG_WINDOW_LENGTH = 3'd3;
	localparam logic [2:0] REG_SEED_USAGE = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_SCAN,
		ST_DIV,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic        use_average;
		logic [15:0] buffer_factor;
		logic [30:0] empty_threshold;
		logic [6:0]  window_length;
		logic [30:0] seed_usage;
	} cfg_t;
endpackage
`default_nettype wire

>>> sv/wdre_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module wdre_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> sv/wdre_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module wdre_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output wdre_pkg::cfg_t   cfg
);
	import wdre_pkg::*;

	logic [2:0] idx;
	assign idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.use_average <= 1'b0;
			cfg.buffer_factor <= 16'd8192;
			cfg.empty_threshold <= '0;
			cfg.window_length <= 7'd24;
			cfg.seed_usage <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_USE_AVERAGE:     cfg.use_average <= pwdata[0];
				REG_BUFFER_FACTOR:   cfg.buffer_factor <= pwdata[15:0];
				REG_EMPTY_THRESHOLD: cfg.empty_threshold <= pwdata[30:0];
				REG_WINDOW_LENGTH:   cfg.window_length <= pwdata[6:0];
				REG_SEED_USAGE:      cfg.seed_usage <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_USE_AVERAGE:     prdata = {31'd0, cfg.use_average};
			REG_BUFFER_FACTOR:   prdata = {16'd0, cfg.buffer_factor};
			REG_EMPTY_THRESHOLD: prdata = {1'b0, cfg.empty_threshold};
			REG_WINDOW_LENGTH:   prdata = {25'd0, cfg.window_length};
			REG_SEED_USAGE:      prdata = {1'b0, cfg.seed_usage};
			default:             prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

>>> sv/wdre_div.sv
`timescale 1ns / 1ps
`default_nettype none
module wdre_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          go,
	input  wire logic signed [38:0]            dividend,
	input  wire logic [wdre_pkg::CNT_W-1:0]    divisor,
	output logic                               done,
	output logic signed [31:0]                 quotient
);
	import wdre_pkg::*;

	logic [38:0] mag_q;
	logic [CNT_W-1:0] rem_q;
	logic neg_q;
	logic [5:0] step_q;
	logic busy_q;
	logic [CNT_W:0] trial;
	logic [38:0] q_abs;

	assign trial = {rem_q, mag_q[38]} - {1'b0, divisor};
	assign q_abs = neg_q ? (~mag_q + 39'd1) : mag_q;
	assign quotient = q_abs[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				step_q <= 6'd0;
			end else if (busy_q) begin
				step_q <= step_q + 6'd1;
				if (step_q == 6'd38) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			neg_q <= dividend[38];
			mag_q <= dividend[38] ? 39'(-dividend) : dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[CNT_W]) begin
				rem_q <= trial[CNT_W-1:0];
				mag_q <= {mag_q[37:0], 1'b1};
			end else begin
				rem_q <= {rem_q[CNT_W-2:0], mag_q[38]};
				mag_q <= {mag_q[37:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

>>> sv/windowed_demand_refill_estimator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// One result word per command: the history scan reads each counted entry in turn before
// done; the mean adds a restoring divide and seeding an empty history adds a seed state.
// Busy falls as done rises, and the next word may start then. Reset clears the control
// state and loads the register defaults; the history memory is not cleared, as only
// counted entries are read. The receiver cannot stall.
module windowed_demand_refill_estimator_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cmd,
	input  wire logic [30:0] qty_before,
	input  wire logic [30:0] qty_after,
	input  wire logic [30:0] current_qty,
	output logic             done,
	output logic [30:0]      to_move,
	output logic [30:0]      to_hold,
	output logic signed [31:0] usage_estimate,
	output logic signed [31:0] recorded_usage
);
	import wdre_pkg::*;

	cfg_t cfg;
	state_t state_q, state_d;

	logic cmd_q;
	logic [30:0] pre_q, post_q, cur_q;
	logic [IDX_W-1:0] oldest_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;
	logic rd_valid_s1;
	logic signed [38:0] acc_q;
	logic signed [31:0] est_q;
	logic signed [48:0] prod_q;

	logic we;
	logic [IDX_W-1:0] waddr, raddr;
	logic [31:0] wdata, rdata;
	logic div_go, div_done;
	logic signed [31:0] div_q;
	logic signed [38:0] div_num;

	logic [CNT_W-1:0] win;
	logic signed [48:0] scaled;
	logic signed [31:0] scaled_sat;
	logic signed [49:0] mv_full;
	logic [30:0] mv;
	logic [31:0] hold_full;
	logic signed [31:0] used;
	logic [CNT_W-1:0] cnt_inc;

	assign pready = 1'b1;

	wdre_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
	);

	wdre_ram #(.WIDTH(32), .DEPTH(WINDOW_MAX)) u_hist (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	assign div_num = acc_q + 39'(signed'(rdata));

	wdre_div u_div (
		.clk, .arst_n, .go(div_go), .dividend(div_num), .divisor(count_q),
		.done(div_done), .quotient(div_q)
	);

	assign busy = (state_q != ST_IDLE);
	assign raddr = oldest_q + scan_q[IDX_W-1:0];

	always_comb begin
		if (cfg.window_length == 7'd0) win = CNT_W'(1);
		else if (cfg.window_length > 7'(WINDOW_MAX)) win = CNT_W'(WINDOW_MAX);
		else win = CNT_W'(cfg.window_length);
	end

	// Truncation toward zero of est*factor/4096.
	assign scaled = prod_q[48] ? -((-prod_q) >>> BUF_FRAC) : (prod_q >>> BUF_FRAC);
	always_comb begin
		if (scaled > 49'sd2147483647) scaled_sat = 32'sh7FFFFFFF;
		else if (scaled < -49'sd2147483648) scaled_sat = 32'sh80000000;
		else scaled_sat = scaled[31:0];
	end

	assign mv_full = 50'(scaled) - 50'(signed'({1'b0, cur_q}));
	always_comb begin
		if (mv_full < 0) mv = '0;
		else if (mv_full > 50'sd2147483647) mv = QTY_MAX;
		else mv = mv_full[30:0];
	end
	assign hold_full = {1'b0, cur_q} + {1'b0, mv};

	always_comb begin
		if (pre_q <= cfg.empty_threshold) used = est_q;
		else if ($signed({1'b0, pre_q}) >= est_q && post_q <= cfg.empty_threshold)
			used = scaled_sat;
		else used = $signed({1'b0, pre_q}) - $signed({1'b0, post_q});
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = (count_q == '0) ? ST_SEED : ST_SCAN;
			ST_SEED: state_d = ST_SCAN;
			ST_SCAN: if (rd_valid_s1 && scan_q == count_q)
				state_d = cfg.use_average ? ST_DIV : ST_MUL;
			ST_DIV:  if (div_done) state_d = ST_MUL;
			ST_MUL:  state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		div_go = 1'b0;
		unique case (state_q)
			ST_SEED: begin
				we = 1'b1;
				wdata = {1'b0, cfg.seed_usage};
			end
			ST_SCAN: div_go = rd_valid_s1 && scan_q == count_q && cfg.use_average;
			ST_DONE: begin
				we = (cmd_q == CMD_UPDATE);
				waddr = oldest_q + count_q[IDX_W-1:0];
				wdata = used;
			end
			default: ;
		endcase
	end

	assign cnt_inc = count_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			oldest_q <= '0;
			count_q <= '0;
			scan_q <= '0;
			rd_valid_s1 <= 1'b0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					scan_q <= '0;
					rd_valid_s1 <= 1'b0;
				end
				ST_SEED: begin
					oldest_q <= '0;
					count_q <= CNT_W'(1);
				end
				ST_SCAN: begin
					if (scan_q != count_q) begin
						scan_q <= scan_q + CNT_W'(1);
						rd_valid_s1 <= 1'b1;
					end else begin
						rd_valid_s1 <= 1'b0;
					end
				end
				ST_DONE: begin
					done <= 1'b1;
					if (cmd_q == CMD_UPDATE) begin
						if (cnt_inc > win) oldest_q <= oldest_q + IDX_W'(1);
						else count_q <= cnt_inc;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd;
			pre_q <= qty_before;
			post_q <= qty_after;
			cur_q <= current_qty;
			acc_q <= '0;
		end
		if (state_q == ST_SCAN && rd_valid_s1) begin
			if (cfg.use_average) acc_q <= acc_q + 39'(signed'(rdata));
			else if ($signed(rdata) > acc_q) acc_q <= 39'(signed'(rdata));
		end
		if (state_q == ST_SCAN && rd_valid_s1 && scan_q == count_q && !cfg.use_average)
			est_q <= ($signed(rdata) > acc_q) ? $signed(rdata) : acc_q[31:0];
		if (state_q == ST_DIV && div_done) est_q <= div_q;
		if (state_q == ST_MUL)
			prod_q <= 49'(est_q) * 49'(signed'({1'b0, cfg.buffer_factor}));
		if (state_q == ST_DONE) begin
			usage_estimate <= est_q;
			if (cmd_q == CMD_QUERY) begin
				to_move <= mv;
				to_hold <= hold_full[31] ? QTY_MAX : hold_full[30:0];
				recorded_usage <= '0;
			end else begin
				to_move <= '0;
				to_hold <= '0;
				recorded_usage <= used;
			end
		end
	end
endmodule
`default_nettype wire

>>> tb/windowed_demand_refill_estimator_unit_tb.sv
`timescale 1ns / 1ps
module windowed_demand_refill_estimator_unit_tb;
	import wdre_pkg::*;

	typedef struct {
		bit          is_cfg;
		logic [2:0]  reg_idx;
		logic [31:0] reg_val;
		bit          cmd;
		logic [30:0] pre_qty;
		logic [30:0] post_qty;
		logic [30:0] cur_qty;
		int          gap;
	} op_t;

	typedef struct {
		logic [30:0]        move_amt;
		logic [30:0]        hold_amt;
		logic signed [31:0] est;
		logic signed [31:0] rec;
	} refill_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel, penable, pwrite, pready, start, busy, cmd, done;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;
	logic [30:0] qty_before, qty_after, current_qty, to_move, to_hold;
	logic signed [31:0] usage_estimate, recorded_usage;

	windowed_demand_refill_estimator_unit dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .cmd(cmd), .qty_before(qty_before),
		.qty_after(qty_after), .current_qty(current_qty), .done(done),
		.to_move(to_move), .to_hold(to_hold), .usage_estimate(usage_estimate),
		.recorded_usage(recorded_usage)
	);

	always #5 clk = ~clk;

	op_t pending_ops[$];
	refill_word_t expected_words[$];
	op_t cur_op;
	int gap_left;
	int mismatches = 0;
	int n_updates = 0, n_queries = 0, n_writes = 0, n_words = 0;

	// Shadow of the block's registers and history.
	bit          m_avg = 1'b0;
	logic [15:0] m_buf = 16'd8192;
	logic [30:0] m_thr = '0;
	logic [6:0]  m_win = 7'd24;
	logic [30:0] m_guess = '0;
	int          m_hist[WINDOW_MAX];
	int          m_oldest = 0;
	int          m_count = 0;

	function automatic longint scale_usage(int est);
		return (longint'(est) * longint'(m_buf)) / 4096;
	endfunction

	function automatic refill_word_t predict_refill(op_t o);
		longint pre, post, cur, thr, mv, hold, sum, sc;
		int est, used, w, i, v;
		refill_word_t r;
		pre = o.pre_qty;
		post = o.post_qty;
		cur = o.cur_qty;
		thr = m_thr;
		if (m_count == 0) begin
			m_oldest = 0;
			m_hist[0] = int'(m_guess);
			m_count = 1;
		end
		if (!m_avg) begin
			est = 0;
			for (i = 0; i < m_count; i++) begin
				v = m_hist[(m_oldest + i) % WINDOW_MAX];
				if (v > est)
					est = v;
			end
		end else begin
			sum = 0;
			for (i = 0; i < m_count; i++)
				sum += m_hist[(m_oldest + i) % WINDOW_MAX];
			est = int'(sum / m_count);
		end
		r.est = est;
		if (o.cmd == CMD_QUERY) begin
			mv = scale_usage(est) - cur;
			if (mv < 0)
				mv = 0;
			if (mv > QTY_MAX)
				mv = QTY_MAX;
			hold = cur + mv;
			if (hold > QTY_MAX)
				hold = QTY_MAX;
			r.move_amt = mv[30:0];
			r.hold_amt = hold[30:0];
			r.rec = 0;
		end else begin
			used = int'(pre - post);
			w = m_win;
			if (w < 1)
				w = 1;
			if (w > WINDOW_MAX)
				w = WINDOW_MAX;
			if (pre <= thr) begin
				used = est;
			end else if (pre >= longint'(est) && post <= thr) begin
				sc = scale_usage(est);
				if (sc > 64'sd2147483647)
					used = 32'sh7FFFFFFF;
				else if (sc < -64'sd2147483648)
					used = 32'sh80000000;
				else
					used = int'(sc);
			end
			m_hist[(m_oldest + m_count) % WINDOW_MAX] = used;
			m_count++;
			if (m_count > w) begin
				m_oldest = (m_oldest + 1) % WINDOW_MAX;
				m_count--;
			end
			r.move_amt = '0;
			r.hold_amt = '0;
			r.rec = used;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= '0;
			pwdata <= '0;
			cmd <= 1'b0;
			qty_before <= '0;
			qty_after <= '0;
			current_qty <= '0;
			gap_left <= 0;
		end else if (psel && penable) begin
			case (cur_op.reg_idx)
				REG_USE_AVERAGE: m_avg = cur_op.reg_val[0];
				REG_BUFFER_FACTOR: m_buf = cur_op.reg_val[15:0];
				REG_EMPTY_THRESHOLD: m_thr = cur_op.reg_val[30:0];
				REG_WINDOW_LENGTH: m_win = cur_op.reg_val[6:0];
				REG_SEED_USAGE: m_guess = cur_op.reg_val[30:0];
				default: ;
			endcase
			n_writes++;
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
		end else if (psel) begin
			penable <= 1'b1;
		end else if (start && !busy) begin
			expected_words.insert(expected_words.size(), predict_refill(cur_op));
			if (cur_op.cmd == CMD_QUERY)
				n_queries++;
			else
				n_updates++;
			start <= 1'b0;
			gap_left <= cur_op.gap;
		end else if (start) begin
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
		end else if (pending_ops.size() > 0) begin
			if (pending_ops[0].is_cfg) begin
				if (expected_words.size() == 0 && !busy) begin
					cur_op = pending_ops[0];
					pending_ops.delete(0);
					psel <= 1'b1;
					pwrite <= 1'b1;
					paddr <= {cur_op.reg_idx, 2'b00};
					pwdata <= cur_op.reg_val;
				end
			end else begin
				cur_op = pending_ops[0];
				pending_ops.delete(0);
				cmd <= cur_op.cmd;
				qty_before <= cur_op.pre_qty;
				qty_after <= cur_op.post_qty;
				current_qty <= cur_op.cur_qty;
				start <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: to_move %h to_hold %h est %h rec %h",
						to_move, to_hold, usage_estimate, recorded_usage);
			end else begin
				refill_word_t e;
				e = expected_words[0];
				expected_words.delete(0);
				n_words++;
				if (e.move_amt !== to_move || e.hold_amt !== to_hold ||
					e.est !== usage_estimate || e.rec !== recorded_usage) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word %0d mismatch: to_move %h/%h to_hold %h/%h est %h/%h rec %h/%h",
							n_words, e.move_amt, to_move, e.hold_amt, to_hold,
							e.est, usage_estimate, e.rec, recorded_usage);
				end
			end
		end
	end

	bit gen_idle;
	logic [30:0] gen_thr;

	task automatic add_cfg(logic [2:0] idx, logic [31:0] val);
		op_t o;
		o = '{default: 0};
		o.is_cfg = 1'b1;
		o.reg_idx = idx;
		o.reg_val = val;
		if (idx == REG_EMPTY_THRESHOLD)
			gen_thr = val[30:0];
		pending_ops.insert(pending_ops.size(), o);
	endtask

	task automatic add_item(bit c, logic [30:0] pre, logic [30:0] post, logic [30:0] cur);
		op_t o;
		o = '{default: 0};
		o.cmd = c;
		o.pre_qty = pre;
		o.post_qty = post;
		o.cur_qty = cur;
		o.gap = (gen_idle && $urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
		pending_ops.insert(pending_ops.size(), o);
	endtask

	function automatic logic [30:0] rand_qty();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return QTY_MAX;
			2: return 31'($urandom);
			3: return 31'($urandom_range(0, 1 << 20));
			4: return gen_thr + 31'($urandom_range(0, 2)) - 31'd1;
			default: return 31'($urandom_range(0, 1 << 24));
		endcase
	endfunction

	initial begin
		logic [30:0] a, b;
		int p, k, cycles;
		gen_idle = 1'b1;
		gen_thr = '0;
		// Large seed so the very first estimate is at its maximum and its scaled value saturates.
		add_cfg(REG_SEED_USAGE, 32'h7FFFFFFF);
		add_cfg(REG_BUFFER_FACTOR, 32'hFFFF);
		add_item(CMD_QUERY, '0, '0, '0);
		add_item(CMD_QUERY, QTY_MAX, QTY_MAX, QTY_MAX);
		add_item(CMD_UPDATE, QTY_MAX, '0, '0);
		add_item(CMD_UPDATE, '0, QTY_MAX, '0);
		add_item(CMD_UPDATE, 31'd100, 31'd200, '0);
		add_item(CMD_UPDATE, QTY_MAX, QTY_MAX, QTY_MAX);
		add_item(CMD_UPDATE, 31'd5, '0, '0);
		add_item(CMD_QUERY, '0, '0, 31'd1);
		add_cfg(REG_USE_AVERAGE, 32'd1);
		add_cfg(REG_EMPTY_THRESHOLD, 32'h0001_0000);
		add_cfg(REG_WINDOW_LENGTH, 32'd2);
		add_item(CMD_QUERY, '0, '0, 31'h0000_8000);
		add_item(CMD_UPDATE, 31'h0001_0000, '0, '0);
		add_item(CMD_UPDATE, 31'h0001_0001, 31'h0001_0000, '0);
		add_item(CMD_UPDATE, 31'h0002_0000, 31'h0003_0000, '0);
		add_item(CMD_UPDATE, 31'h0005_0000, 31'h0001_0000, '0);
		add_item(CMD_QUERY, '0, '0, '0);
		add_item(CMD_QUERY, '0, '0, QTY_MAX);

		for (p = 0; p < 10; p++) begin
			gen_idle = (p < 9) && (p % 3 != 1);
			case (p)
				0: begin
					add_cfg(REG_USE_AVERAGE, 32'd0);
					add_cfg(REG_BUFFER_FACTOR, 32'd0);
					add_cfg(REG_EMPTY_THRESHOLD, 32'd0);
					add_cfg(REG_WINDOW_LENGTH, 32'd1);
				end
				1: begin
					add_cfg(REG_USE_AVERAGE, 32'd1);
					add_cfg(REG_BUFFER_FACTOR, 32'hFFFF);
					add_cfg(REG_EMPTY_THRESHOLD, 32'h7FFFFFFF);
					add_cfg(REG_WINDOW_LENGTH, 32'd64);
				end
				2: begin
					add_cfg(REG_EMPTY_THRESHOLD, 32'h0000_1000);
					add_cfg(REG_WINDOW_LENGTH, 32'd0);
				end
				3: begin
					add_cfg(REG_USE_AVERAGE, 32'd0);
					add_cfg(REG_WINDOW_LENGTH, 32'd127);
					add_cfg(REG_BUFFER_FACTOR, 32'd4096);
				end
				default: begin
					add_cfg(REG_USE_AVERAGE, 32'($urandom_range(0, 1)));
					add_cfg(REG_BUFFER_FACTOR, 32'($urandom_range(0, 16'hFFFF)));
					add_cfg(REG_EMPTY_THRESHOLD, 32'($urandom_range(0, 1 << 22)));
					add_cfg(REG_WINDOW_LENGTH, 32'($urandom_range(1, 64)));
				end
			endcase
			add_cfg(REG_SEED_USAGE, 32'($urandom) & 32'h7FFFFFFF);
			for (k = 0; k < 190; k++) begin
				a = rand_qty();
				if ($urandom_range(0, 3) != 0) begin
					b = (a == 0) ? rand_qty() : 31'($urandom_range(0, a));
					if ($urandom_range(0, 5) == 0)
						b = gen_thr;
					add_item(CMD_UPDATE, a, b, rand_qty());
				end else begin
					add_item(CMD_QUERY, rand_qty(), rand_qty(), a);
				end
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_ops.size() > 0 || start || psel || expected_words.size() > 0 || busy)
			@(posedge clk);
		cycles = 0;
		while (cycles < 200) begin
			@(posedge clk);
			cycles++;
		end
		if (expected_words.size() > 0)
			mismatches++;
		$display("Covered %0d updates and %0d queries over %0d register writes,", n_updates,
			n_queries, n_writes);
		$display("both estimate modes, window lengths 0 to 127 and saturating buffer factors.");
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end
endmodule
